// ----- rtl/core/lasa_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the
// skyline rectangle allocator. No dependencies.
package lasa_pkg;

  localparam int DEF_PAGE_COUNT  = 256;
  localparam int DEF_PAGE_WIDTH  = 128;
  localparam int DEF_PAGE_HEIGHT = 128;

  localparam int CMD_W    = 1;
  localparam int SIZE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int PAGE_W   = 8;
  localparam int POS_X_W  = 7;
  localparam int POS_Y_W  = 7;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 1'b1;

  localparam logic [STATUS_W-1:0] ST_PLACED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd3;

  typedef struct packed {
    logic                load;
    logic                sweep_start;
    logic                sweep;
    logic                page_init;
    logic                page_next;
    logic                scan;
    logic                write_start;
    logic                write;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                out_load;
  } lasa_cmd_t;

  typedef struct packed {
    logic bad_size;
    logic too_tall;
    logic sweep_last;
    logic scan_end;
    logic fits;
    logic last_page;
    logic write_last;
    logic out_free;
  } lasa_stat_t;

endpackage

// ----- rtl/core/lightmap_atlas_skyline_alloc_core.sv -----
// Top level of the skyline rectangle allocator: joins the controller and the
// datapath. Depends on lasa_pkg, lasa_ctrl and lasa_datapath.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_ready  command, rect_width, rect_height
//   out      out_valid / out_ready status, page_index, pos_x, pos_y
//
// One item is in work at a time; the next is taken while the last result
// still waits in the output register. An allocate item scans the pages in
// turn and then writes rect_width columns, its pace set by the single read
// port of the height memory, one column a cycle. A bad size or over-tall
// item goes from idle straight to the result. A clear item and reset each
// run a clearing pass over all PAGE_COUNT * PAGE_WIDTH entries, one entry a
// cycle, with in_ready low.
module lightmap_atlas_skyline_alloc_core import lasa_pkg::*; #(
  parameter int PAGE_COUNT  = DEF_PAGE_COUNT,
  parameter int PAGE_WIDTH  = DEF_PAGE_WIDTH,
  parameter int PAGE_HEIGHT = DEF_PAGE_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    command,
  input  logic [SIZE_W-1:0]   rect_width,
  input  logic [SIZE_W-1:0]   rect_height,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [PAGE_W-1:0]   page_index,
  output logic [POS_X_W-1:0]  pos_x,
  output logic [POS_Y_W-1:0]  pos_y
);

  lasa_cmd_t  cmd;
  lasa_stat_t stat;

  lasa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lasa_datapath #(
    .PAGE_COUNT  (PAGE_COUNT),
    .PAGE_WIDTH  (PAGE_WIDTH),
    .PAGE_HEIGHT (PAGE_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .page_index  (page_index),
    .pos_x       (pos_x),
    .pos_y       (pos_y)
  );

endmodule

// ----- rtl/core/lasa_ctrl.sv -----
// Controller state machine of the skyline allocator: sequences the clearing
// pass, the page scans, the column update and the result. Depends on lasa_pkg.
module lasa_ctrl import lasa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] command,
  output logic             in_ready,
  input  lasa_stat_t       stat,
  output lasa_cmd_t        cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_PSTART = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_WRITE  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       report;
  logic       report_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      report <= 1'b0;
    end else begin
      state  <= state_next;
      report <= report_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    report_next = report;
    cmd         = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          if (report) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_CLEARED;
            report_next     = 1'b0;
            state_next      = S_DONE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (command == CMD_CLEAR) begin
            cmd.sweep_start = 1'b1;
            report_next     = 1'b1;
            state_next      = S_CLEAR;
          end else if (stat.bad_size) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_BAD_SIZE;
            state_next      = S_DONE;
          end else if (stat.too_tall) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_FULL;
            state_next      = S_DONE;
          end else begin
            state_next = S_PSTART;
          end
        end
      end
      S_PSTART: begin
        cmd.page_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.fits) begin
          cmd.write_start = 1'b1;
          state_next      = S_WRITE;
        end else if (stat.last_page) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_FULL;
          state_next      = S_DONE;
        end else begin
          cmd.page_next = 1'b1;
          state_next    = S_PSTART;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        if (stat.write_last) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_PLACED;
          state_next      = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/lasa_datapath.sv -----
// Datapath of the skyline allocator: column height memory, scan registers,
// best-position tracking and the output register. Depends on lasa_pkg.
module lasa_datapath import lasa_pkg::*; #(
  parameter int PAGE_COUNT  = DEF_PAGE_COUNT,
  parameter int PAGE_WIDTH  = DEF_PAGE_WIDTH,
  parameter int PAGE_HEIGHT = DEF_PAGE_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [SIZE_W-1:0]   rect_width,
  input  logic [SIZE_W-1:0]   rect_height,
  input  lasa_cmd_t           cmd,
  output lasa_stat_t          stat,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [STATUS_W-1:0] status,
  output logic [PAGE_W-1:0]   page_index,
  output logic [POS_X_W-1:0]  pos_x,
  output logic [POS_Y_W-1:0]  pos_y
);

  localparam int N   = PAGE_COUNT * PAGE_WIDTH;
  localparam int AW  = $clog2(N);
  localparam int CW  = $clog2(PAGE_WIDTH);
  localparam int HW  = $clog2(PAGE_HEIGHT + 1);
  localparam int PGW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int SW  = ((HW > SIZE_W) ? HW : SIZE_W) + 1;
  localparam int LW  = ((CW > SIZE_W) ? CW : SIZE_W) + 1;

  logic [HW-1:0]     mem [0:N-1];
  logic [HW-1:0]     rdata;
  logic              we;
  logic [AW-1:0]     wa;
  logic [HW-1:0]     wd;
  logic [AW-1:0]     ra;

  logic [AW-1:0]     sweep_addr;
  logic [SIZE_W-1:0] h;
  logic [CW-1:0]     w_m1;
  logic [CW-1:0]     last_start;
  logic [PGW-1:0]    page;
  logic [AW-1:0]     page_base;
  logic [CW-1:0]     start;
  logic [CW-1:0]     k;
  logic [CW-1:0]     col;
  logic [HW-1:0]     sky;
  logic [HW-1:0]     best;
  logic [CW-1:0]     best_x;

  logic [STATUS_W-1:0] res_status;
  logic [PAGE_W-1:0]   res_page;
  logic [POS_X_W-1:0]  res_x;
  logic [POS_Y_W-1:0]  res_y;

  logic          fail;
  logic          col_done;
  logic          start_end;
  logic          at_last;
  logic [HW-1:0] sky_max;
  logic [CW-1:0] col_next;
  logic [HW-1:0] top;

  assign fail      = (rdata >= best);
  assign sky_max   = (rdata > sky) ? rdata : sky;
  assign col_done  = (k == w_m1);
  assign start_end = fail || col_done;
  assign at_last   = (start == last_start);
  assign col_next  = start_end ? (start + CW'(1)) : (col + CW'(1));
  assign top       = HW'(SW'(best) + SW'(h));

  assign stat.bad_size   = (rect_width == '0) || (LW'(rect_width) > LW'(PAGE_WIDTH))
                           || (rect_height == '0);
  assign stat.too_tall   = (SW'(rect_height) > SW'(PAGE_HEIGHT));
  assign stat.sweep_last = (sweep_addr == AW'(N - 1));
  assign stat.scan_end   = start_end && at_last;
  assign stat.fits       = ((SW'(best) + SW'(h)) <= SW'(PAGE_HEIGHT));
  assign stat.last_page  = (page == PGW'(PAGE_COUNT - 1));
  assign stat.write_last = col_done;
  assign stat.out_free   = !out_valid || out_ready;

  assign we = cmd.sweep || cmd.write;
  assign wa = cmd.sweep ? sweep_addr : (page_base + AW'(col));
  assign wd = cmd.sweep ? '0 : top;
  assign ra = cmd.page_init ? page_base : (page_base + AW'(col_next));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep_start) begin
      sweep_addr <= '0;
    end else if (cmd.sweep) begin
      sweep_addr <= sweep_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      h          <= rect_height;
      w_m1       <= CW'(LW'(rect_width) - LW'(1));
      last_start <= CW'(LW'(PAGE_WIDTH) - LW'(rect_width));
      page       <= '0;
      page_base  <= '0;
    end
    if (cmd.page_next) begin
      page      <= page + PGW'(1);
      page_base <= page_base + AW'(PAGE_WIDTH);
    end
    if (cmd.page_init) begin
      best   <= HW'(PAGE_HEIGHT);
      best_x <= '0;
      start  <= '0;
      k      <= '0;
      col    <= '0;
      sky    <= '0;
    end
    if (cmd.scan) begin
      if (!start_end) begin
        k   <= k + CW'(1);
        col <= col_next;
        sky <= sky_max;
      end else begin
        if (!fail) begin
          best   <= sky_max;
          best_x <= start;
        end
        if (!at_last) begin
          start <= start + CW'(1);
          col   <= col_next;
          k     <= '0;
          sky   <= '0;
        end
      end
    end
    if (cmd.write_start) begin
      col <= best_x;
      k   <= '0;
    end
    if (cmd.write) begin
      col <= col + CW'(1);
      k   <= k + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_status) begin
      res_status <= cmd.status_code;
      if (cmd.status_code == ST_PLACED) begin
        res_page <= PAGE_W'(page);
        res_x    <= POS_X_W'(best_x);
        res_y    <= POS_Y_W'(best);
      end else begin
        res_page <= '0;
        res_x    <= '0;
        res_y    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status     <= res_status;
      page_index <= res_page;
      pos_x      <= res_x;
      pos_y      <= res_y;
    end
  end

endmodule

// ----- rtl/core/lasa_checker.sv -----
// Port-level checks for the skyline allocator top level, attached by bind.
// Depends on lasa_pkg and lightmap_atlas_skyline_alloc_core.
module lasa_checker import lasa_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [PAGE_W-1:0]   page_index,
  input logic [POS_X_W-1:0]  pos_x,
  input logic [POS_Y_W-1:0]  pos_y
);

  // The clearing pass after reset keeps the input closed.
  a_reset_clears: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input open right after reset");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in work");

  // Results other than a placement carry zero position fields.
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_PLACED) |->
      (page_index == '0 && pos_x == '0 && pos_y == '0))
    else $error("nonzero position on a result that is not a placement");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(status) && $stable(page_index)
       && $stable(pos_x) && $stable(pos_y)))
    else $error("stalled result changed");

endmodule

bind lightmap_atlas_skyline_alloc_core lasa_checker u_lasa_checker (.*);
